[rtl/gbn_arq_pkg.sv]
package gbn_arq_pkg;

    // event codes
    localparam logic [2:0] FN_PACKET  = 3'd0;
    localparam logic [2:0] FN_PHY     = 3'd1;
    localparam logic [2:0] FN_FRAME   = 3'd2;
    localparam logic [2:0] FN_DATA_TO = 3'd3;
    localparam logic [2:0] FN_ACK_TO  = 3'd4;

    // received frame kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    // command codes
    localparam logic [2:0] CMD_SEND_DATA  = 3'd0;
    localparam logic [2:0] CMD_SEND_ACK   = 3'd1;
    localparam logic [2:0] CMD_DELIVER    = 3'd2;
    localparam logic [2:0] CMD_STOP_TIMER = 3'd3;
    localparam logic [2:0] CMD_ACK_TIMER  = 3'd4;
    localparam logic [2:0] CMD_STATUS     = 3'd5;

    // longest run of result beats per event, status included
    localparam int MAX_RESULTS = 11;
    localparam int CNT_W       = 4;
    localparam int ECNT_W      = 4;

    typedef struct packed {
        logic [2:0] func;
        logic       crc_ok;
        logic [1:0] frame_kind;
        logic [2:0] frame_seq;
        logic [2:0] peer_ack;
    } gbn_in_t;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] seq_num;
        logic [2:0] ack_num;
        logic       net_enable;
        logic       last;
    } gbn_out_t;

endpackage

[rtl/gbn_arq_alu.sv]
module gbn_arq_alu
    import gbn_arq_pkg::*;
#(
    parameter int MAX_SEQ_NUM = 7,
    parameter int SEQ_W       = 3,
    parameter int FW          = 3
)
(
    input  logic [FW-1:0]    inc_in,
    output logic [FW-1:0]    inc_out,
    input  logic [SEQ_W-1:0] dec_in,
    output logic [SEQ_W-1:0] dec_out,
    input  logic [FW-1:0]    win_a,
    input  logic [FW-1:0]    win_b,
    input  logic [FW-1:0]    win_c,
    output logic             in_win
);

    localparam logic [FW-1:0]    MAX_F = FW'(MAX_SEQ_NUM);
    localparam logic [SEQ_W-1:0] MAX_S = SEQ_W'(MAX_SEQ_NUM);

    // successor of a 3-bit ack that lies beyond the sequence space
    logic [FW-1:0] wrap_tab [8];

    for (genvar g = 0; g < 8; g++) begin : g_wrap
        localparam int WRAP_VAL = (g + 1) % (MAX_SEQ_NUM + 1);
        assign wrap_tab[g] = FW'(WRAP_VAL);
    end

    always_comb
    begin
        if (inc_in < MAX_F)
        begin
            inc_out = inc_in + FW'(1);
        end
        else if (inc_in == MAX_F)
        begin
            inc_out = '0;
        end
        else
        begin
            inc_out = wrap_tab[inc_in[2:0]];
        end
    end

    assign dec_out = (dec_in == '0) ? MAX_S : dec_in - SEQ_W'(1);

    // circular half-open window [a, c)
    assign in_win = ((win_a <= win_b) && (win_b < win_c)) ||
                    ((win_c < win_a) && (win_a <= win_b)) ||
                    ((win_b < win_c) && (win_c < win_a));

endmodule

[rtl/go_back_n_arq_controller_core.sv]
// go-back-n window control, one event accepted while busy is low
// each event's run of result beats ends with the status beat
// no new event is accepted until the previous event's run has reached its status beat
// the single shared increment / window compare unit sets the pace, one step a cycle
// the receiver cannot stall: each result beat is on the ports for one cycle
// asynchronous active-low reset clears all window state and the sequencer
module go_back_n_arq_controller_core
    import gbn_arq_pkg::*;
#(
    parameter int MAX_SEQ_NUM = 7
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  gbn_in_t  req,
    output logic     strobe,
    output gbn_out_t rsp
);

    localparam int SEQ_W = (MAX_SEQ_NUM < 2) ? 1 : $clog2(MAX_SEQ_NUM + 1);
    localparam int FW    = (SEQ_W > 3) ? SEQ_W : 3;
    localparam int CW    = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;
    localparam logic [CW-1:0]     MAX_C    = CW'(MAX_SEQ_NUM);
    localparam logic [ECNT_W-1:0] ECNT_CAP = ECNT_W'(MAX_RESULTS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEND     = 4'd1;
    localparam logic [3:0] S_DELIV    = 4'd2;
    localparam logic [3:0] S_ATIMER   = 4'd3;
    localparam logic [3:0] S_NAK_INC  = 4'd4;
    localparam logic [3:0] S_NAK_CHK  = 4'd5;
    localparam logic [3:0] S_ACK_LOOP = 4'd6;
    localparam logic [3:0] S_TO_LOOP  = 4'd7;
    localparam logic [3:0] S_ACKTO    = 4'd8;
    localparam logic [3:0] S_STATUS   = 4'd9;

    logic [3:0]       state_reg, state_next;
    gbn_in_t          in_reg, in_next;
    logic [SEQ_W-1:0] re_reg, re_next;
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] snext_reg, snext_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             line_reg, line_next;
    logic [FW-1:0]    rs_reg, rs_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [ECNT_W-1:0] ecnt_reg, ecnt_next;
    gbn_out_t         out_reg, out_next;
    logic             strobe_reg, strobe_next;

    logic [FW-1:0]    inc_in, inc_out;
    logic [SEQ_W-1:0] ack_val;
    logic [FW-1:0]    win_b;
    logic             in_win;
    logic             emit_req;
    gbn_out_t         emit_item;
    logic             is_status;
    logic             win_open;

    gbn_arq_alu #(
        .MAX_SEQ_NUM (MAX_SEQ_NUM),
        .SEQ_W       (SEQ_W),
        .FW          (FW)
    ) u_alu (
        .inc_in  (inc_in),
        .inc_out (inc_out),
        .dec_in  (re_reg),
        .dec_out (ack_val),
        .win_a   (FW'(base_reg)),
        .win_b   (win_b),
        .win_c   (FW'(snext_reg)),
        .in_win  (in_win)
    );

    assign win_open = (CW'(cnt_reg) < MAX_C);

    // shared unit operand select
    always_comb
    begin
        case (state_reg)
            S_ATIMER:   inc_in = FW'(re_reg);
            S_NAK_INC:  inc_in = FW'(in_reg.peer_ack);
            S_ACK_LOOP: inc_in = FW'(base_reg);
            default:    inc_in = FW'(snext_reg);
        endcase
        win_b = (state_reg == S_NAK_CHK) ? rs_reg : FW'(in_reg.peer_ack);
    end

    always_comb
    begin
        state_next = state_reg;
        in_next    = in_reg;
        re_next    = re_reg;
        base_next  = base_reg;
        snext_next = snext_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        rs_next    = rs_reg;
        i_next     = i_reg;
        ecnt_next  = ecnt_reg;
        emit_req   = 1'b0;
        is_status  = 1'b0;
        emit_item  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next   = req;
                    ecnt_next = '0;
                    case (req.func)
                        FN_PACKET:  state_next = S_SEND;
                        FN_PHY:
                        begin
                            line_next  = 1'b1;
                            state_next = S_STATUS;
                        end
                        FN_FRAME:   state_next = req.crc_ok ? S_DELIV : S_STATUS;
                        FN_DATA_TO:
                        begin
                            snext_next = base_reg;
                            i_next     = '0;
                            state_next = S_TO_LOOP;
                        end
                        FN_ACK_TO:  state_next = S_ACKTO;
                        default:    state_next = S_STATUS;
                    endcase
                end
            end
            S_SEND:
            begin
                if (win_open)
                begin
                    emit_req          = 1'b1;
                    emit_item.command = CMD_SEND_DATA;
                    emit_item.seq_num = 3'(snext_reg);
                    emit_item.ack_num = 3'(ack_val);
                    line_next         = 1'b0;
                    cnt_next          = cnt_reg + CNT_W'(1);
                    snext_next        = SEQ_W'(inc_out);
                end
                state_next = S_STATUS;
            end
            S_DELIV:
            begin
                if (in_reg.frame_kind == KIND_DATA &&
                    FW'(in_reg.frame_seq) == FW'(re_reg))
                begin
                    emit_req          = 1'b1;
                    emit_item.command = CMD_DELIVER;
                    emit_item.seq_num = in_reg.frame_seq;
                    state_next        = S_ATIMER;
                end
                else
                begin
                    state_next = S_NAK_INC;
                end
            end
            S_ATIMER:
            begin
                emit_req          = 1'b1;
                emit_item.command = CMD_ACK_TIMER;
                re_next           = SEQ_W'(inc_out);
                state_next        = S_NAK_INC;
            end
            S_NAK_INC:
            begin
                if (in_reg.frame_kind == KIND_NAK)
                begin
                    rs_next    = inc_out;
                    state_next = S_NAK_CHK;
                end
                else
                begin
                    state_next = S_ACK_LOOP;
                end
            end
            S_NAK_CHK:
            begin
                if (in_win)
                begin
                    emit_req          = 1'b1;
                    emit_item.command = CMD_SEND_DATA;
                    emit_item.seq_num = 3'(rs_reg);
                    emit_item.ack_num = 3'(ack_val);
                    line_next         = 1'b0;
                end
                state_next = S_ACK_LOOP;
            end
            S_ACK_LOOP:
            begin
                // cumulative ack, one frame retired per cycle
                if (in_win)
                begin
                    emit_req          = 1'b1;
                    emit_item.command = CMD_STOP_TIMER;
                    emit_item.seq_num = 3'(base_reg);
                    base_next         = SEQ_W'(inc_out);
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_TO_LOOP:
            begin
                if (i_reg < cnt_reg)
                begin
                    emit_req          = 1'b1;
                    emit_item.command = CMD_SEND_DATA;
                    emit_item.seq_num = 3'(snext_reg);
                    emit_item.ack_num = 3'(ack_val);
                    line_next         = 1'b0;
                    snext_next        = SEQ_W'(inc_out);
                    i_next            = i_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_ACKTO:
            begin
                emit_req          = 1'b1;
                emit_item.command = CMD_SEND_ACK;
                emit_item.ack_num = 3'(ack_val);
                line_next         = 1'b0;
                state_next        = S_STATUS;
            end
            S_STATUS:
            begin
                is_status            = 1'b1;
                emit_item.command    = CMD_STATUS;
                emit_item.net_enable = win_open && line_reg;
                emit_item.last       = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // commands past the run limit are dropped, state still moves
        strobe_next = 1'b0;
        out_next    = out_reg;
        if (is_status)
        begin
            strobe_next = 1'b1;
            out_next    = emit_item;
        end
        else if (emit_req && ecnt_reg < ECNT_CAP)
        begin
            strobe_next = 1'b1;
            out_next    = emit_item;
            ecnt_next   = ecnt_reg + ECNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            re_reg     <= '0;
            base_reg   <= '0;
            snext_reg  <= '0;
            cnt_reg    <= '0;
            line_reg   <= 1'b0;
            i_reg      <= '0;
            ecnt_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            re_reg     <= re_next;
            base_reg   <= base_next;
            snext_reg  <= snext_next;
            cnt_reg    <= cnt_next;
            line_reg   <= line_next;
            i_reg      <= i_next;
            ecnt_reg   <= ecnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        rs_reg  <= rs_next;
        out_reg <= out_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign rsp    = out_reg;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted event did not start the sequencer");

    a_run_ends_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && rsp.last && rsp.command == CMD_STATUS)
        else $error("event finished without a status beat");

    a_cmd_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rsp.last |-> busy)
        else $error("command beat outside an event run");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(cnt_reg) <= MAX_C)
        else $error("outstanding count beyond window size");

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= ECNT_CAP)
        else $error("command run exceeded limit");
`endif

endmodule

[test/tb.sv]
module tb;
    import gbn_arq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // event and kind codes the package leaves unnamed
    localparam logic [2:0] FN_RSVD_LO = 3'd5;
    localparam logic [2:0] FN_RSVD_HI = 3'd7;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam int SEQ_LIMIT      = 7;
    localparam int PHASE_EVENTS   = 149;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_GAP        = 200;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        gbn_in_t    ev;
        logic [1:0] n_typed;
        gbn_out_t   first;
        gbn_out_t   second;
    } stim_row_t;

    localparam gbn_out_t NONE       = '0;
    localparam gbn_out_t STATUS_ON  = '{CMD_STATUS, 3'd0, 3'd0, 1'b1, 1'b1};
    localparam gbn_out_t STATUS_OFF = '{CMD_STATUS, 3'd0, 3'd0, 1'b0, 1'b1};
    localparam gbn_out_t ACK_RESET  = '{CMD_SEND_ACK, 3'd0, 3'd7, 1'b0, 1'b0};
    localparam gbn_out_t DATA_RESET = '{CMD_SEND_DATA, 3'd0, 3'd7, 1'b0, 1'b0};

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{'{FN_ACK_TO,  1'b0, KIND_DATA, 3'd0, 3'd0}, 2'd2, ACK_RESET, STATUS_OFF},
        '{'{FN_PHY,     1'b1, KIND_RSVD, 3'd7, 3'd7}, 2'd1, STATUS_ON, NONE},
        '{'{FN_RSVD_LO, 1'b0, KIND_DATA, 3'd0, 3'd0}, 2'd1, STATUS_ON, NONE},
        '{'{FN_RSVD_HI, 1'b1, KIND_RSVD, 3'd7, 3'd7}, 2'd1, STATUS_ON, NONE},
        '{'{FN_FRAME,   1'b0, KIND_DATA, 3'd0, 3'd7}, 2'd1, STATUS_ON, NONE},
        '{'{FN_PACKET,  1'b0, KIND_DATA, 3'd0, 3'd0}, 2'd2, DATA_RESET, STATUS_OFF},
        '{'{FN_PACKET,  1'b1, KIND_RSVD, 3'd7, 3'd7}, 2'd0, NONE, NONE},
        '{'{FN_PACKET,  1'b0, KIND_NAK,  3'd2, 3'd5}, 2'd0, NONE, NONE},
        '{'{FN_PACKET,  1'b1, KIND_ACK,  3'd5, 3'd2}, 2'd0, NONE, NONE},
        '{'{FN_PACKET,  1'b0, KIND_DATA, 3'd7, 3'd0}, 2'd0, NONE, NONE},
        '{'{FN_PACKET,  1'b1, KIND_NAK,  3'd0, 3'd7}, 2'd0, NONE, NONE},
        '{'{FN_PACKET,  1'b0, KIND_ACK,  3'd3, 3'd4}, 2'd0, NONE, NONE},
        // window full, packet refused
        '{'{FN_PACKET,  1'b1, KIND_DATA, 3'd0, 3'd0}, 2'd1, STATUS_OFF, NONE},
        '{'{FN_FRAME,   1'b1, KIND_DATA, 3'd0, 3'd7}, 2'd0, NONE, NONE},
        // out of order data is dropped
        '{'{FN_FRAME,   1'b1, KIND_DATA, 3'd5, 3'd7}, 2'd0, NONE, NONE},
        '{'{FN_DATA_TO, 1'b0, KIND_DATA, 3'd0, 3'd0}, 2'd0, NONE, NONE},
        '{'{FN_FRAME,   1'b1, KIND_NAK,  3'd0, 3'd2}, 2'd0, NONE, NONE},
        '{'{FN_FRAME,   1'b1, KIND_RSVD, 3'd0, 3'd4}, 2'd0, NONE, NONE},
        '{'{FN_PHY,     1'b0, KIND_DATA, 3'd0, 3'd0}, 2'd0, NONE, NONE},
        '{'{FN_FRAME,   1'b1, KIND_ACK,  3'd7, 3'd6}, 2'd0, NONE, NONE},
        '{'{FN_FRAME,   1'b1, KIND_ACK,  3'd0, 3'd0}, 2'd0, NONE, NONE},
        '{'{FN_DATA_TO, 1'b1, KIND_RSVD, 3'd7, 3'd7}, 2'd0, NONE, NONE},
        '{'{FN_ACK_TO,  1'b1, KIND_RSVD, 3'd7, 3'd7}, 2'd0, NONE, NONE},
        '{'{FN_FRAME,   1'b0, KIND_RSVD, 3'd7, 3'd7}, 2'd0, NONE, NONE}
    };

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    gbn_in_t  req;
    logic     strobe;
    gbn_out_t rsp;

    // window model
    logic [2:0] rx_expected;
    logic [2:0] tx_base;
    logic [2:0] tx_next;
    logic [3:0] tx_outstanding;
    bit         phy_ready;

    gbn_out_t    predicted_run [$];
    gbn_out_t    pending_cmds [$];
    gbn_out_t    want_beat;
    int unsigned mismatch_cnt;
    int unsigned quiet_cycles;

    go_back_n_arq_controller_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .strobe (strobe),
        .rsp    (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [2:0] outgoing_ack();
        return rx_expected - 3'd1;
    endfunction

    // b inside the circular half-open range [a, c)
    function automatic bit seq_between(logic [2:0] a, logic [2:0] b, logic [2:0] c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    function automatic void push_cmd(logic [2:0] cmd, logic [2:0] seq, logic [2:0] ack);
        if (predicted_run.size() < MAX_RESULTS)
            predicted_run.push_back('{cmd, seq, ack, 1'b0, 1'b0});
    endfunction

    function automatic void push_frame(logic [2:0] seq);
        phy_ready = 1'b0;
        push_cmd(CMD_SEND_DATA, seq, outgoing_ack());
    endfunction

    function automatic void predict_event(gbn_in_t ev);
        logic [2:0] resend;
        logic       en;
        predicted_run.delete();
        case (ev.func)
            FN_PACKET:
            begin
                if (tx_outstanding < SEQ_LIMIT)
                begin
                    push_frame(tx_next);
                    tx_outstanding = tx_outstanding + 4'd1;
                    tx_next = tx_next + 3'd1;
                end
            end
            FN_PHY:
                phy_ready = 1'b1;
            FN_FRAME:
            begin
                if (ev.crc_ok)
                begin
                    if (ev.frame_kind == KIND_DATA && ev.frame_seq == rx_expected)
                    begin
                        push_cmd(CMD_DELIVER, ev.frame_seq, 3'd0);
                        push_cmd(CMD_ACK_TIMER, 3'd0, 3'd0);
                        rx_expected = rx_expected + 3'd1;
                    end
                    if (ev.frame_kind == KIND_NAK)
                    begin
                        resend = ev.peer_ack + 3'd1;
                        if (seq_between(tx_base, resend, tx_next))
                            push_frame(resend);
                    end
                    // cumulative ack
                    while (seq_between(tx_base, ev.peer_ack, tx_next))
                    begin
                        push_cmd(CMD_STOP_TIMER, tx_base, 3'd0);
                        tx_base = tx_base + 3'd1;
                        if (tx_outstanding != 4'd0)
                            tx_outstanding = tx_outstanding - 4'd1;
                    end
                end
            end
            FN_DATA_TO:
            begin
                tx_next = tx_base;
                for (int i = 0; i < tx_outstanding; i++)
                begin
                    push_frame(tx_next);
                    tx_next = tx_next + 3'd1;
                end
            end
            FN_ACK_TO:
            begin
                phy_ready = 1'b0;
                push_cmd(CMD_SEND_ACK, 3'd0, outgoing_ack());
            end
            default:
                ;
        endcase
        while (predicted_run.size() > MAX_RESULTS - 1)
            void'(predicted_run.pop_back());
        en = (tx_outstanding < SEQ_LIMIT) && phy_ready;
        predicted_run.push_back('{CMD_STATUS, 3'd0, 3'd0, en, 1'b1});
    endfunction

    // mostly well-formed traffic steered by the window state, some raw noise
    function automatic gbn_in_t random_event();
        gbn_in_t     ev;
        int unsigned pick;
        int unsigned kind_pick;
        ev = gbn_in_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            return ev;
        else if (pick < 33)
            ev.func = FN_PACKET;
        else if (pick < 48)
            ev.func = FN_PHY;
        else if (pick < 84)
        begin
            ev.func = FN_FRAME;
            ev.crc_ok = ($urandom_range(99) < 85);
            kind_pick = $urandom_range(9);
            if (kind_pick < 4)
                ev.frame_kind = KIND_DATA;
            else if (kind_pick < 7)
                ev.frame_kind = KIND_ACK;
            else if (kind_pick < 9)
                ev.frame_kind = KIND_NAK;
            else
                ev.frame_kind = KIND_RSVD;
            if ($urandom_range(1) != 0)
                ev.frame_seq = rx_expected;
            if (tx_outstanding != 4'd0 && $urandom_range(2) != 0)
            begin
                ev.peer_ack = tx_base + 3'($urandom_range(tx_outstanding - 1));
                // aim the nak so that its resend lands inside the window
                if (ev.frame_kind == KIND_NAK && $urandom_range(1) != 0)
                    ev.peer_ack = ev.peer_ack - 3'd1;
            end
        end
        else if (pick < 92)
            ev.func = FN_DATA_TO;
        else
            ev.func = FN_ACK_TO;
        return ev;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_beat(input gbn_out_t got, input gbn_out_t want);
        if (got.command !== want.command)
            report_mismatch("command", got.command, want.command);
        if (got.seq_num !== want.seq_num)
            report_mismatch("seq_num", got.seq_num, want.seq_num);
        if (got.ack_num !== want.ack_num)
            report_mismatch("ack_num", got.ack_num, want.ack_num);
        if (got.net_enable !== want.net_enable)
            report_mismatch("net_enable", got.net_enable, want.net_enable);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    task automatic send_event(input gbn_in_t ev, input int unsigned idle_pct,
                              input logic [1:0] n_typed, input gbn_out_t first,
                              input gbn_out_t second);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < MAX_GAP)
            gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= ev;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_event(ev);
        if (n_typed != 2'd0)
        begin
            predicted_run.delete();
            predicted_run.push_back(first);
            if (n_typed > 2'd1)
                predicted_run.push_back(second);
        end
        foreach (predicted_run[k])
            pending_cmds.push_back(predicted_run[k]);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (strobe === 1'b1)
            begin
                if (pending_cmds.size() == 0)
                    report_mismatch("unexpected beat, command", rsp.command, -1);
                else
                begin
                    want_beat = pending_cmds.pop_front();
                    check_beat(rsp, want_beat);
                end
            end
            if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        rx_expected = '0;
        tx_base = '0;
        tx_next = '0;
        tx_outstanding = '0;
        phy_ready = 1'b0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_event(DIRECTED[r].ev, 19, DIRECTED[r].n_typed,
                       DIRECTED[r].first, DIRECTED[r].second);
        wait_all_results();

        // busy sender, then a sparse one, then back to back
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < PHASE_EVENTS; n++)
                send_event(random_event(), (phase == 0) ? 19 : (phase == 1) ? 84 : 0,
                           2'd0, NONE, NONE);
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
